// ===== hw/rtl/ssa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and codes of the swap slot allocator: opcodes, status
// codes, the broadcast request and the token that walks the cell row.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int OPCODE_W = 2;
    localparam int TID_W    = 16;
    localparam int PAGE_W   = 20;
    localparam int TAG_W    = TID_W + PAGE_W;
    localparam int STATUS_W = 2;
    localparam int SLOTNO_W = 10;
    localparam int SECTOR_W = 13;
    localparam int LIMIT_W  = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // Request opcodes (code three behaves as a query)
    localparam logic [OPCODE_W-1:0] OP_ALLOCATE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY    = 2'd2;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Request held for the whole scan and seen by every cell
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [TAG_W-1:0]    tag;
    } scan_req_t;

    // Search state handed from cell to cell
    typedef struct packed {
        logic valid;  // token sits in this stage
        logic found;  // a used slot with the same tag has been passed
        logic taken;  // a slot has been chosen (claimed, released or matched)
    } scan_tok_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssa_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_req_if
// Request channel of the swap slot allocator: valid/ready with the
// opcode and the tag parts.
// ----------------------------------------------------------------------------
interface ssa_req_if;

    logic                          valid;
    logic                          ready;
    logic [ssa_pkg::OPCODE_W-1:0]  opcode;
    logic [ssa_pkg::TID_W-1:0]     thread_id;
    logic [ssa_pkg::PAGE_W-1:0]    user_page;

    modport source (output valid, output opcode, output thread_id, output user_page,
                    input ready);
    modport sink   (input valid, input opcode, input thread_id, input user_page,
                    output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/ssa_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_rsp_if
// Response channel of the swap slot allocator: valid/ready with status,
// found flag, slot number and first sector.
// ----------------------------------------------------------------------------
interface ssa_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [ssa_pkg::STATUS_W-1:0]  status;
    logic                          found;
    logic [ssa_pkg::SLOTNO_W-1:0]  slot_number;
    logic [ssa_pkg::SECTOR_W-1:0]  start_sector;

    modport source (output valid, output status, output found, output slot_number,
                    output start_sector, input ready);
    modport sink   (input valid, input status, input found, input slot_number,
                    input start_sector, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/ssa_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_cell
// One swap slot: holds its used flag and tag, inspects the passing
// token, claims or frees itself when chosen and hands the token on.
// ----------------------------------------------------------------------------
module ssa_cell #(
    parameter int IDX_W = 10,
    parameter int IDX   = 0
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  ssa_pkg::scan_req_t         req,
    input  wire  [ssa_pkg::LIMIT_W-1:0]      limit,
    input  wire  ssa_pkg::scan_tok_t         tok_in,
    input  wire  [IDX_W-1:0]                 slot_in,
    output ssa_pkg::scan_tok_t               tok_out,
    output logic [IDX_W-1:0]                 slot_out
);

    localparam int CMP_W = ((IDX_W > ssa_pkg::LIMIT_W) ? IDX_W : ssa_pkg::LIMIT_W) + 1;
    localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(IDX);
    localparam logic [CMP_W-1:0] MY_POS  = CMP_W'(IDX);

    logic                          used_reg, used_next;
    logic [ssa_pkg::TAG_W-1:0]     tag_reg, tag_next;
    ssa_pkg::scan_tok_t            tok_reg, tok_next;
    logic [IDX_W-1:0]              slot_reg, slot_next;

    logic                          tag_hit;
    logic                          usable;

    // Compare this slot against the request
    assign tag_hit = used_reg && (tag_reg == req.tag);
    assign usable  = (CMP_W'(limit) > MY_POS);

    // Decide what this slot does as the token passes
    always_comb
    begin
        used_next = used_reg;
        tag_next  = tag_reg;
        tok_next  = tok_in;
        slot_next = slot_in;
        if (tok_in.valid)
        begin
            if (req.op == ssa_pkg::OP_ALLOCATE)
            begin
                if (tag_hit)
                begin
                    tok_next.found = 1'b1;
                end
                if (!tok_in.taken && !used_reg && usable)
                begin
                    used_next      = 1'b1;
                    tag_next       = req.tag;
                    tok_next.taken = 1'b1;
                    slot_next      = MY_SLOT;
                end
            end
            else if (!tok_in.taken && tag_hit)
            begin
                tok_next.found = 1'b1;
                tok_next.taken = 1'b1;
                slot_next      = MY_SLOT;
                if (req.op == ssa_pkg::OP_RELEASE)
                begin
                    used_next = 1'b0;
                end
            end
        end
    end

    // Hold slot state and advance the token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        slot_reg <= slot_next;
    end

    assign tok_out  = tok_reg;
    assign slot_out = slot_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/swap_slot_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swap_slot_allocator
// First-fit swap slot allocator built as a row of slot cells that a
// search token walks through.
// ----------------------------------------------------------------------------
// Each request (allocate, release, query) is answered once a search
// token has walked the row, visiting one slot cell per cycle; a hold
// register then catches the finished token and the response register is
// loaded from it. Each cell claims, frees or matches itself as the token
// passes. The next request is taken from the cycle after the response is
// loaded. The response sits in an output register, so one new request is
// taken while the previous response still waits; a stalled response then
// holds back the end of that next scan. The occupancy flags clear at
// reset with no extra pass; slot_limit (cfg_we/cfg_wdata) may be
// written only while no request is in flight.
// ----------------------------------------------------------------------------
module swap_slot_allocator #(
    parameter int NUM_SLOTS        = 1024,
    parameter int SECTORS_PER_SLOT = 8
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire  [ssa_pkg::LIMIT_W-1:0]   cfg_wdata,
    ssa_req_if.sink                       req,
    ssa_rsp_if.source                     rsp
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [ssa_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    ssa_pkg::scan_req_t            req_reg, req_next;
    logic                          busy_reg, busy_next;
    logic                          start_reg, start_next;
    logic                          hold_valid_reg, hold_valid_next;
    ssa_pkg::scan_tok_t            hold_tok_reg, hold_tok_next;
    logic [IDX_W-1:0]              hold_slot_reg, hold_slot_next;
    logic                          out_valid_reg, out_valid_next;
    logic [ssa_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          found_reg, found_next;
    logic [ssa_pkg::SLOTNO_W-1:0]  slot_number_reg, slot_number_next;
    logic [ssa_pkg::SECTOR_W-1:0]  start_sector_reg, start_sector_next;

    ssa_pkg::scan_tok_t            tok_chain  [NUM_SLOTS+1];
    logic [IDX_W-1:0]              slot_chain [NUM_SLOTS+1];

    logic                          req_xfer;
    logic                          out_load;
    logic [31:0]                   slot_w;
    logic [31:0]                   sector_w;

    assign req_xfer  = req.valid && req.ready;
    assign req.ready = !busy_reg;
    assign out_load  = hold_valid_reg && (!out_valid_reg || rsp.ready);

    // Launch a fresh token into the first cell
    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = start_reg;
        slot_chain[0]      = '0;
    end

    // Row of slot cells
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        ssa_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (req_reg),
            .limit    (limit_reg),
            .tok_in   (tok_chain[i]),
            .slot_in  (slot_chain[i]),
            .tok_out  (tok_chain[i+1]),
            .slot_out (slot_chain[i+1])
        );
    end

    // Register the request, track the scan and catch the finished token
    always_comb
    begin
        limit_next      = cfg_we ? cfg_wdata : limit_reg;
        req_next        = req_reg;
        busy_next       = busy_reg;
        start_next      = req_xfer;
        hold_valid_next = hold_valid_reg;
        hold_tok_next   = hold_tok_reg;
        hold_slot_next  = hold_slot_reg;
        if (req_xfer)
        begin
            req_next.op  = req.opcode;
            req_next.tag = {req.thread_id, req.user_page};
            busy_next    = 1'b1;
        end
        if (tok_chain[NUM_SLOTS].valid)
        begin
            hold_valid_next = 1'b1;
            hold_tok_next   = tok_chain[NUM_SLOTS];
            hold_slot_next  = slot_chain[NUM_SLOTS];
        end
        else if (out_load)
        begin
            hold_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    // Build the response fields from the finished token
    assign slot_w   = 32'(hold_slot_reg);
    assign sector_w = slot_w * 32'(SECTORS_PER_SLOT);

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        found_next        = found_reg;
        slot_number_next  = slot_number_reg;
        start_sector_next = start_sector_reg;
        if (out_load)
        begin
            out_valid_next    = 1'b1;
            found_next        = hold_tok_reg.found;
            slot_number_next  = slot_w[ssa_pkg::SLOTNO_W-1:0];
            start_sector_next = sector_w[ssa_pkg::SECTOR_W-1:0];
            if (hold_tok_reg.taken)
            begin
                status_next = ssa_pkg::ST_OK;
            end
            else if (req_reg.op == ssa_pkg::OP_ALLOCATE)
            begin
                status_next = ssa_pkg::ST_FULL;
            end
            else
            begin
                status_next = ssa_pkg::ST_NOT_FOUND;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= ssa_pkg::LIMIT_RESET;
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            limit_reg      <= limit_next;
            busy_reg       <= busy_next;
            start_reg      <= start_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg          <= req_next;
        hold_tok_reg     <= hold_tok_next;
        hold_slot_reg    <= hold_slot_next;
        status_reg       <= status_next;
        found_reg        <= found_next;
        slot_number_reg  <= slot_number_next;
        start_sector_reg <= start_sector_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.found        = found_reg;
    assign rsp.slot_number  = slot_number_reg;
    assign rsp.start_sector = start_sector_reg;

endmodule

`default_nettype wire

// ===== dv/tb_swap_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swap_slot_allocator
// Self-checking bench for the swap slot allocator. A cycle-free model of
// the slot table (occupancy flags, tags, usable limit) predicts status,
// found flag, slot number and first sector for every request transfer.
// Directed tests cover the empty table, extreme tags, duplicates, opcode
// three and the limit extremes. Random traffic runs over a small tag pool
// under changing limits, with bursts of idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb_swap_slot_allocator;

    localparam int TABLE_DEPTH    = 1024;
    localparam int SECTORS        = 8;
    localparam int STALL_LIMIT    = 6000;
    localparam int POOL_SIZE      = 12;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 56;

    // Opcode three has no name in the package; it behaves as a query
    localparam logic [ssa_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;

    localparam logic [ssa_pkg::TID_W-1:0]  TID_MAX  = '1;
    localparam logic [ssa_pkg::PAGE_W-1:0] PAGE_MAX = '1;

    typedef struct packed {
        logic [ssa_pkg::OPCODE_W-1:0] op;
        logic [ssa_pkg::TID_W-1:0]    tid;
        logic [ssa_pkg::PAGE_W-1:0]   page;
    } swap_req_t;

    typedef struct packed {
        logic [ssa_pkg::STATUS_W-1:0] status;
        logic                         found;
        logic [ssa_pkg::SLOTNO_W-1:0] slot_number;
        logic [ssa_pkg::SECTOR_W-1:0] start_sector;
    } swap_rsp_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [ssa_pkg::LIMIT_W-1:0]   cfg_wdata;

    ssa_req_if req_ch ();
    ssa_rsp_if rsp_ch ();

    swap_slot_allocator #(
        .NUM_SLOTS        (TABLE_DEPTH),
        .SECTORS_PER_SLOT (SECTORS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Slot table as the bench sees it
    bit                            slot_busy [TABLE_DEPTH];
    logic [ssa_pkg::TAG_W-1:0]     slot_key  [TABLE_DEPTH];
    logic [ssa_pkg::LIMIT_W-1:0]   usable_limit;

    swap_req_t           pending_reqs [$];
    swap_rsp_t           expected_rsp [$];
    swap_req_t           next_req;
    swap_rsp_t           due;

    logic [ssa_pkg::TID_W-1:0]     pool_tid  [POOL_SIZE];
    logic [ssa_pkg::PAGE_W-1:0]    pool_page [POOL_SIZE];

    bit                  idle_on;
    int                  hold_off;
    int                  stall_left;
    int                  quiet_cycles;
    int                  queued_total;
    int                  answered_total;
    int                  mismatches;
    int                  n_alloc, n_release, n_query, n_full, n_missing, n_limits;

    // Work out the response to one request and update the slot table
    function automatic swap_rsp_t predict_request(input logic [ssa_pkg::OPCODE_W-1:0] op,
                                                  input logic [ssa_pkg::TID_W-1:0] tid,
                                                  input logic [ssa_pkg::PAGE_W-1:0] page);
        logic [ssa_pkg::TAG_W-1:0] key;
        int               hit;
        int               spare;
        int               usable;
        int               chosen;
        logic [31:0]      sector;
        swap_rsp_t        r;
        key    = {tid, page};
        hit    = -1;
        spare  = -1;
        chosen = 0;
        usable = (usable_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(usable_limit);
        r      = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (hit < 0 && slot_busy[i] && slot_key[i] == key)
                hit = i;
        r.found = (hit >= 0);
        if (op == ssa_pkg::OP_ALLOCATE)
        begin
            n_alloc++;
            for (int i = 0; i < usable; i++)
                if (spare < 0 && !slot_busy[i])
                    spare = i;
            if (spare >= 0)
            begin
                slot_busy[spare] = 1'b1;
                slot_key[spare]  = key;
                chosen           = spare;
                r.status         = ssa_pkg::ST_OK;
            end
            else
            begin
                r.status = ssa_pkg::ST_FULL;
                n_full++;
            end
        end
        else
        begin
            if (op == ssa_pkg::OP_RELEASE)
                n_release++;
            else
                n_query++;
            if (hit >= 0)
            begin
                if (op == ssa_pkg::OP_RELEASE)
                    slot_busy[hit] = 1'b0;
                chosen   = hit;
                r.status = ssa_pkg::ST_OK;
            end
            else
            begin
                r.status = ssa_pkg::ST_NOT_FOUND;
                n_missing++;
            end
        end
        sector         = 32'(chosen * SECTORS);
        r.slot_number  = chosen[ssa_pkg::SLOTNO_W-1:0];
        r.start_sector = sector[ssa_pkg::SECTOR_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Queue one request for the driver
    task automatic send_request(input logic [ssa_pkg::OPCODE_W-1:0] op,
                                input logic [ssa_pkg::TID_W-1:0] tid,
                                input logic [ssa_pkg::PAGE_W-1:0] page);
        swap_req_t item;
        item.op   = op;
        item.tid  = tid;
        item.page = page;
        pending_reqs.push_back(item);
        queued_total++;
    endtask

    // Hold until every queued request has had its response
    task automatic wait_for_idle();
        while (answered_total < queued_total)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [ssa_pkg::LIMIT_W-1:0] value);
        wait_for_idle();
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        usable_limit  = value;
        n_limits++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Request driver: advance to the next queued item once the current one transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsp.push_back(predict_request(req_ch.opcode, req_ch.thread_id,
                                                       req_ch.user_page));
                hold_off = (idle_on && $urandom_range(0, 3) == 0) ?
                           int'($urandom_range(1, 9)) : 0;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (hold_off > 0)
                begin
                    hold_off--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_req            = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.opcode      <= next_req.op;
                    req_ch.thread_id   <= next_req.tid;
                    req_ch.user_page   <= next_req.page;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response checker and ready stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                answered_total++;
                if (expected_rsp.size() == 0)
                begin
                    $error("response transfer with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    due = expected_rsp.pop_front();
                    check_field("status", 16'(due.status), 16'(rsp_ch.status));
                    check_field("found", 16'(due.found), 16'(rsp_ch.found));
                    check_field("slot_number", 16'(due.slot_number),
                                16'(rsp_ch.slot_number));
                    check_field("start_sector", 16'(due.start_sector),
                                16'(rsp_ch.start_sector));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = int'($urandom_range(0, 8));
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: drop out if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Lookups and frees on an empty table
    task automatic test_empty_table();
        send_request(ssa_pkg::OP_QUERY, TID_MAX, PAGE_MAX);
        send_request(ssa_pkg::OP_RELEASE, '0, '0);
        send_request(OP_SPARE, '0, '0);
    endtask

    // Extreme tags, duplicates, lowest match and reuse of freed slots
    task automatic test_allocate_release();
        send_request(ssa_pkg::OP_ALLOCATE, '0, '0);
        send_request(ssa_pkg::OP_ALLOCATE, TID_MAX, PAGE_MAX);
        send_request(ssa_pkg::OP_ALLOCATE, TID_MAX, PAGE_MAX);
        send_request(ssa_pkg::OP_QUERY, TID_MAX, PAGE_MAX);
        send_request(ssa_pkg::OP_RELEASE, TID_MAX, PAGE_MAX);
        send_request(ssa_pkg::OP_QUERY, TID_MAX, PAGE_MAX);
        send_request(OP_SPARE, '0, '0);
        send_request(ssa_pkg::OP_ALLOCATE, 16'hA5A5, 20'h5A5A5);
        send_request(ssa_pkg::OP_RELEASE, '0, '0);
    endtask

    // Zero limit, one slot, saturating limit, full table, slots above the limit
    task automatic test_limit_extremes();
        write_limit(11'd0);
        send_request(ssa_pkg::OP_ALLOCATE, TID_MAX, PAGE_MAX);
        write_limit(11'd1);
        send_request(ssa_pkg::OP_ALLOCATE, '0, '0);
        send_request(ssa_pkg::OP_ALLOCATE, '0, '0);
        write_limit(11'd2047);
        send_request(ssa_pkg::OP_ALLOCATE, 16'h0001, 20'h00001);
        write_limit(11'd4);
        send_request(ssa_pkg::OP_ALLOCATE, 16'h0002, 20'h00002);
        write_limit(11'd1);
        send_request(ssa_pkg::OP_QUERY, TID_MAX, PAGE_MAX);
        send_request(ssa_pkg::OP_RELEASE, 16'hA5A5, 20'h5A5A5);
        send_request(ssa_pkg::OP_RELEASE, TID_MAX, PAGE_MAX);
        write_limit(ssa_pkg::LIMIT_RESET);
    endtask

    // Mixed traffic over a small tag pool, one limit per phase
    task automatic test_random_traffic();
        logic [ssa_pkg::LIMIT_W-1:0] phase_limit;
        int                          pick;
        int                          slot;
        logic [ssa_pkg::TID_W-1:0]   tid;
        logic [ssa_pkg::PAGE_W-1:0]  page;
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            pool_tid[p]  = 16'($urandom_range(0, 16'hFFFF));
            pool_page[p] = 20'($urandom_range(0, 20'hFFFFF));
        end
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       phase_limit = 11'd8;
                1:       phase_limit = 11'd1;
                2:       phase_limit = 11'd24;
                3:       phase_limit = 11'd0;
                4:       phase_limit = 11'd2047;
                5:       phase_limit = 11'd3;
                6:       phase_limit = ssa_pkg::LIMIT_RESET;
                default: phase_limit = 11'($urandom_range(1, 32));
            endcase
            write_limit(phase_limit);
            // Last phase runs with no idling on either side
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = int'($urandom_range(0, 99));
                slot = int'($urandom_range(0, POOL_SIZE - 1));
                if ($urandom_range(0, 4) == 0)
                begin
                    tid  = 16'($urandom_range(0, 16'hFFFF));
                    page = 20'($urandom_range(0, 20'hFFFFF));
                    // Refresh a pool entry now and then
                    if ($urandom_range(0, 3) == 0)
                    begin
                        pool_tid[slot]  = tid;
                        pool_page[slot] = page;
                    end
                end
                else
                begin
                    tid  = pool_tid[slot];
                    page = pool_page[slot];
                end
                if (pick < 40)
                    send_request(ssa_pkg::OP_ALLOCATE, tid, page);
                else if (pick < 70)
                    send_request(ssa_pkg::OP_RELEASE, tid, page);
                else if (pick < 90)
                    send_request(ssa_pkg::OP_QUERY, tid, page);
                else
                    send_request(OP_SPARE, tid, page);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_key[i]  = '0;
        end
        usable_limit     = ssa_pkg::LIMIT_RESET;
        idle_on          = 1'b1;
        hold_off         = 0;
        stall_left       = 0;
        quiet_cycles     = 0;
        queued_total     = 0;
        answered_total   = 0;
        mismatches       = 0;
        n_alloc          = 0;
        n_release        = 0;
        n_query          = 0;
        n_full           = 0;
        n_missing        = 0;
        n_limits         = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.opcode    = '0;
        req_ch.thread_id = '0;
        req_ch.user_page = '0;
        rsp_ch.ready     = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_allocate_release();
        test_limit_extremes();
        test_random_traffic();

        // Drain, then give a stray response one full scan to show up
        wait_for_idle();
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        $display("Run covered %0d requests: %0d allocate, %0d release, %0d query or spare",
                 answered_total, n_alloc, n_release, n_query);
        $display("Saw %0d table-full and %0d not-found responses over %0d limit writes",
                 n_full, n_missing, n_limits);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
